/* src/kecf_pkg.sv */
// ----------------------------------------------------------------------------
// kecf_pkg : shared types and constants for the k-mer extraction core
// Word layouts, base encoding, window geometry and the low-complexity limit.
// ----------------------------------------------------------------------------
package kecf_pkg;

  // Window geometry
  localparam int KMER_LENGTH = 13;
  localparam int WINDOW_W    = 2 * KMER_LENGTH;
  localparam int REGION_W    = 20;
  localparam int TALLY_W     = $clog2(KMER_LENGTH + 1);

  // A k-mer whose most frequent base reaches this count is dropped
  localparam logic [TALLY_W-1:0] LOW_CPLX_LIMIT = TALLY_W'(KMER_LENGTH - 2);

  // Tally value of the base that fills an empty window
  localparam logic [TALLY_W-1:0] TALLY_FULL = TALLY_W'(KMER_LENGTH);

  // 2-bit base codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // ASCII character codes
  localparam logic [7:0] CHAR_UC_C = 8'h43;
  localparam logic [7:0] CHAR_LC_C = 8'h63;
  localparam logic [7:0] CHAR_UC_G = 8'h47;
  localparam logic [7:0] CHAR_LC_G = 8'h67;
  localparam logic [7:0] CHAR_UC_T = 8'h54;
  localparam logic [7:0] CHAR_LC_T = 8'h74;

  // Input word: one sequence character
  typedef struct packed {
    logic [7:0]          base_char;
    logic [REGION_W-1:0] region_num;
    logic                strand_reverse;
    logic                last_base;
  } base_word_t;

  // Output word: one emitted k-mer
  typedef struct packed {
    logic [WINDOW_W-1:0] kmer_value;
    logic [REGION_W-1:0] region_out;
    logic                strand_out;
  } kmer_word_t;

  // One window position held by a cell
  typedef struct packed {
    logic       filled;
    logic [1:0] code;
  } base_slot_t;

  // Control from the window row to the base tally
  typedef struct packed {
    logic       advance;
    logic       restart;
    logic [1:0] code_in;
    logic [1:0] code_out;
  } tally_ctrl_t;

  // Map a character to its base code; anything unknown reads as A
  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] code;
    unique case (ch) inside
      CHAR_UC_C, CHAR_LC_C: code = BASE_C;
      CHAR_UC_G, CHAR_LC_G: code = BASE_G;
      CHAR_UC_T, CHAR_LC_T: code = BASE_T;
      default:              code = BASE_A;
    endcase
    return code;
  endfunction

endpackage

/* src/kecf_cell.sv */
// ----------------------------------------------------------------------------
// kecf_cell : one window position
// Holds one base code and its filled mark; takes its neighbour's slot on
// every accepted word and empties when the sequence ends.
// ----------------------------------------------------------------------------
module kecf_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                restart,
  input  kecf_pkg::base_slot_t d,
  output kecf_pkg::base_slot_t q
);

  // Shift in the neighbour's slot, or empty after the last base
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (advance) begin
      if (restart) begin
        q <= '0;
      end else begin
        q <= d;
      end
    end
  end

endmodule

/* src/kecf_tally.sv */
// ----------------------------------------------------------------------------
// kecf_tally : running base counts over the window
// Tracks how often each base sits in the window, updated by the base that
// enters and the one that falls off, and flags low-complexity k-mers.
// ----------------------------------------------------------------------------
module kecf_tally (
  input  logic                  clk,
  input  logic                  rst,
  input  kecf_pkg::tally_ctrl_t ctrl,
  output logic                  complex_ok
);

  logic [kecf_pkg::TALLY_W-1:0] tally      [4];
  logic [kecf_pkg::TALLY_W-1:0] tally_next [4];

  // Add the entering base, remove the leaving one, test against the limit
  always_comb begin
    complex_ok = 1'b1;
    for (int b = 0; b < 4; b++) begin
      tally_next[b] = tally[b];
      if (ctrl.code_in == 2'(b)) begin
        tally_next[b] = tally_next[b] + kecf_pkg::TALLY_W'(1);
      end
      if (ctrl.code_out == 2'(b)) begin
        tally_next[b] = tally_next[b] - kecf_pkg::TALLY_W'(1);
      end
      if (tally_next[b] >= kecf_pkg::LOW_CPLX_LIMIT) begin
        complex_ok = 1'b0;
      end
    end
  end

  // Hold counts; an empty window is all A
  always_ff @(posedge clk) begin
    if (rst || (ctrl.advance && ctrl.restart)) begin
      for (int b = 0; b < 4; b++) begin
        tally[b] <= (2'(b) == kecf_pkg::BASE_A) ? kecf_pkg::TALLY_FULL : '0;
      end
    end else if (ctrl.advance) begin
      for (int b = 0; b < 4; b++) begin
        tally[b] <= tally_next[b];
      end
    end
  end

endmodule

/* src/kmer_extract_complexity_filter_core.sv */
// ----------------------------------------------------------------------------
// kmer_extract_complexity_filter_core : rolling 2-bit k-mer extractor
// Encodes one character per word into a row of window cells and emits each
// full k-mer whose most frequent base stays below the complexity limit.
//
//   channel   direction  handshake                word type
//   base      in         base_valid / base_ready  kecf_pkg::base_word_t
//   kmer      out        kmer_valid / kmer_ready  kecf_pkg::kmer_word_t
//
// One character is taken every cycle while base_ready is high; a k-mer
// appears on the output in the cycle after the character that completes it,
// set by the single output register behind the cell row and the base tally.
// Reset empties the window and the output register; no clearing pass.
// A stalled output blocks input only while its register still holds a word.
// ----------------------------------------------------------------------------
module kmer_extract_complexity_filter_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 base_valid,
  output logic                 base_ready,
  input  kecf_pkg::base_word_t base_word,
  output logic                 kmer_valid,
  input  logic                 kmer_ready,
  output kecf_pkg::kmer_word_t kmer_word
);

  localparam int K = kecf_pkg::KMER_LENGTH;

  logic                          accept;
  logic [1:0]                    code_in;
  kecf_pkg::base_slot_t          slot_d [K];
  kecf_pkg::base_slot_t          slot_q [K];
  logic [kecf_pkg::WINDOW_W-1:0] kmer_next;
  kecf_pkg::tally_ctrl_t         tally_ctrl;
  logic                          complex_ok;
  logic                          emit;

  // Take a word whenever the output register is free or draining
  assign base_ready = !kmer_valid || kmer_ready;
  assign accept     = base_valid && base_ready;
  assign code_in    = kecf_pkg::base_code(base_word.base_char);

  // Feed each cell from its newer neighbour; the newest takes the new base
  always_comb begin
    slot_d[0].filled = 1'b1;
    slot_d[0].code   = code_in;
    for (int i = 1; i < K; i++) begin
      slot_d[i] = slot_q[i-1];
    end
  end

  // Row of window cells, newest at index 0
  for (genvar i = 0; i < K; i++) begin : g_cell
    kecf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (accept),
      .restart (base_word.last_base),
      .d       (slot_d[i]),
      .q       (slot_q[i])
    );
  end

  // Pack the shifted window, oldest base in the high bits
  always_comb begin
    for (int i = 0; i < K; i++) begin
      kmer_next[2*i +: 2] = slot_d[i].code;
    end
  end

  // Base counts follow the entering and leaving codes
  always_comb begin
    tally_ctrl.advance  = accept;
    tally_ctrl.restart  = base_word.last_base;
    tally_ctrl.code_in  = code_in;
    tally_ctrl.code_out = slot_q[K-1].code;
  end

  kecf_tally u_tally (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (tally_ctrl),
    .complex_ok (complex_ok)
  );

  // Emit once the window is full and the k-mer is complex enough
  assign emit = slot_d[K-1].filled && complex_ok;

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_valid <= 1'b0;
    end else if (accept) begin
      kmer_valid <= emit;
    end else if (kmer_ready) begin
      kmer_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kmer_word.kmer_value <= kmer_next;
      kmer_word.region_out <= base_word.region_num;
      kmer_word.strand_out <= base_word.strand_reverse;
    end
  end

endmodule

/* tb/sv/kmer_extract_complexity_filter_core_tb.sv */
// ----------------------------------------------------------------------------
// kmer_extract_complexity_filter_core_tb : self-checking bench for the core
// Streams character words through the core with random gaps on both sides and
// one long output stall. A k-mer tracker forms every expected word from the
// accepted characters, and each k-mer leaving the core is checked against the
// oldest one still pending.
// ----------------------------------------------------------------------------
module kmer_extract_complexity_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 10;

  // Characters with no entry in the package
  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_LC_A = 8'h61;
  localparam logic [7:0] CHAR_UC_N = 8'h4E;

  typedef enum int {SEQ_MIXED, SEQ_REPEAT, SEQ_NOISE} seq_kind_t;

  // Tracks the rolling window and holds the k-mers still owed by the core
  class kmer_tracker;
    logic [kecf_pkg::WINDOW_W-1:0] window;
    int unsigned                   fill;
    kecf_pkg::kmer_word_t          expected_kmers[$];
    int unsigned                   errors;
    int unsigned                   checked;

    function new();
      window  = '0;
      fill    = 0;
      errors  = 0;
      checked = 0;
    endfunction

    static function logic [1:0] char_code(logic [7:0] ch);
      logic [1:0] code;
      case (ch)
        kecf_pkg::CHAR_UC_C, kecf_pkg::CHAR_LC_C: code = kecf_pkg::BASE_C;
        kecf_pkg::CHAR_UC_G, kecf_pkg::CHAR_LC_G: code = kecf_pkg::BASE_G;
        kecf_pkg::CHAR_UC_T, kecf_pkg::CHAR_LC_T: code = kecf_pkg::BASE_T;
        default:                                  code = kecf_pkg::BASE_A;
      endcase
      return code;
    endfunction

    // Shift in one accepted character and note the k-mer it releases, if any
    function void take_base(kecf_pkg::base_word_t w);
      int                   tally[4];
      int                   top;
      kecf_pkg::kmer_word_t kmer;
      window = {window[kecf_pkg::WINDOW_W-3:0], char_code(w.base_char)};
      if (fill < kecf_pkg::KMER_LENGTH) fill++;
      if (fill == kecf_pkg::KMER_LENGTH) begin
        for (int b = 0; b < 4; b++) tally[b] = 0;
        for (int i = 0; i < kecf_pkg::KMER_LENGTH; i++) tally[window[2*i +: 2]]++;
        top = 0;
        for (int b = 0; b < 4; b++) if (tally[b] > top) top = tally[b];
        // drop low-complexity k-mers
        if (top < kecf_pkg::KMER_LENGTH - 2) begin
          kmer.kmer_value = window;
          kmer.region_out = w.region_num;
          kmer.strand_out = w.strand_reverse;
          expected_kmers = {expected_kmers, kmer};
        end
      end
      // restart the window after the final character
      if (w.last_base) begin
        window = '0;
        fill   = 0;
      end
    endfunction

    // Compare one k-mer word from the core with the oldest pending one
    function void check_kmer(kecf_pkg::kmer_word_t got);
      kecf_pkg::kmer_word_t want;
      if (expected_kmers.size() == 0) begin
        $error("kmer word with nothing pending: kmer_value %h region_out %h strand_out %b",
               got.kmer_value, got.region_out, got.strand_out);
        errors++;
        return;
      end
      want = expected_kmers.pop_front();
      checked++;
      if (got.kmer_value !== want.kmer_value) begin
        $error("kmer_value: expected %h, got %h", want.kmer_value, got.kmer_value);
        errors++;
      end
      if (got.region_out !== want.region_out) begin
        $error("region_out: expected %h, got %h", want.region_out, got.region_out);
        errors++;
      end
      if (got.strand_out !== want.strand_out) begin
        $error("strand_out: expected %b, got %b", want.strand_out, got.strand_out);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_kmers.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 base_valid = 1'b0;
  logic                 base_ready;
  kecf_pkg::base_word_t base_word = '0;
  logic                 kmer_valid;
  logic                 kmer_ready = 1'b0;
  kecf_pkg::kmer_word_t kmer_word;

  kmer_tracker tracker = new();
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  kmer_extract_complexity_filter_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .base_valid (base_valid),
    .base_ready (base_ready),
    .base_word  (base_word),
    .kmer_valid (kmer_valid),
    .kmer_ready (kmer_ready),
    .kmer_word  (kmer_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** kmer_extract_complexity_filter_core: FAILED **");
      $finish;
    end
  end

  // Check every k-mer word taken from the core
  always @(posedge clk) begin
    if (!rst && kmer_valid && kmer_ready) tracker.check_kmer(kmer_word);
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Pick a spelling for a base code; code A also takes unknown bytes
  function automatic logic [7:0] char_for(logic [1:0] code);
    logic [7:0] ch;
    case (code)
      kecf_pkg::BASE_C: ch = $urandom_range(0, 1) ? kecf_pkg::CHAR_UC_C : kecf_pkg::CHAR_LC_C;
      kecf_pkg::BASE_G: ch = $urandom_range(0, 1) ? kecf_pkg::CHAR_UC_G : kecf_pkg::CHAR_LC_G;
      kecf_pkg::BASE_T: ch = $urandom_range(0, 1) ? kecf_pkg::CHAR_UC_T : kecf_pkg::CHAR_LC_T;
      default: begin
        case ($urandom_range(0, 3))
          0: ch = CHAR_UC_A;
          1: ch = CHAR_LC_A;
          2: ch = CHAR_UC_N;
          default: begin
            ch = 8'($urandom_range(0, 255));
            if (kmer_tracker::char_code(ch) != kecf_pkg::BASE_A) ch = CHAR_UC_N;
          end
        endcase
      end
    endcase
    return ch;
  endfunction

  // Offer one word and hold it until the core takes it
  task automatic send_base(input kecf_pkg::base_word_t w);
    base_word  <= w;
    base_valid <= 1'b1;
    do @(posedge clk); while (!base_ready);
    tracker.take_base(w);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid for a random stretch unless the sequence runs back to back
  task automatic idle_gap(input bit busy);
    int unsigned gap;
    gap = busy ? 0 : idle_len();
    if (gap != 0) begin
      base_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Send a listed sequence; region and strand flip from switch_at onwards
  task automatic send_listed(input logic [7:0] chars[$],
                             input logic [kecf_pkg::REGION_W-1:0] region,
                             input logic strand, input int switch_at);
    kecf_pkg::base_word_t w;
    for (int i = 0; i < chars.size(); i++) begin
      w.base_char      = chars[i];
      w.region_num     = (i < switch_at) ? region : ~region;
      w.strand_reverse = (i < switch_at) ? strand : ~strand;
      w.last_base      = (i == chars.size() - 1);
      send_base(w);
      idle_gap(1'b0);
    end
  endtask

  // One random sequence: mixed bases, a dominant base, or raw bytes
  task automatic send_random_sequence();
    int unsigned          r;
    int unsigned          len;
    int unsigned          stray;
    seq_kind_t            kind;
    logic [1:0]           major;
    logic [1:0]           code;
    bit                   busy;
    kecf_pkg::base_word_t w;
    r = $urandom_range(0, 99);
    if (r < 10) len = $urandom_range(1, kecf_pkg::KMER_LENGTH - 1);
    else if (r < 80) len = $urandom_range(kecf_pkg::KMER_LENGTH, 30);
    else if (r < 95) len = $urandom_range(31, 80);
    else len = kecf_pkg::KMER_LENGTH;
    r = $urandom_range(0, 99);
    kind  = (r < 55) ? SEQ_MIXED : (r < 90) ? SEQ_REPEAT : SEQ_NOISE;
    major = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 2))
      0: stray = 1;
      1: stray = 3;
      default: stray = 5;
    endcase
    busy             = ($urandom_range(0, 3) == 0);
    w.region_num     = kecf_pkg::REGION_W'($urandom);
    w.strand_reverse = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      case (kind)
        SEQ_MIXED: w.base_char = char_for(2'($urandom_range(0, 3)));
        SEQ_REPEAT: begin
          code = ($urandom_range(0, 15) < stray) ? 2'($urandom_range(0, 3)) : major;
          w.base_char = char_for(code);
        end
        default: w.base_char = 8'($urandom_range(0, 255));
      endcase
      // occasional region or strand change inside the sequence
      if ($urandom_range(0, 49) == 0) w.region_num = kecf_pkg::REGION_W'($urandom);
      if ($urandom_range(0, 49) == 0) w.strand_reverse = ~w.strand_reverse;
      w.last_base = (i == len - 1);
      send_base(w);
      idle_gap(busy);
    end
  endtask

  // Output side: bursts of ready with random stalls, and one long hold-off
  initial begin : kmer_sink
    int unsigned burst;
    int unsigned gap;
    bit          held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && tracker.checked >= 100) begin
        held = 1'b1;
        kmer_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      burst = $urandom_range(1, 40);
      kmer_ready <= 1'b1;
      repeat (burst) @(negedge clk);
      gap = idle_len();
      if (gap != 0) begin
        kmer_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : base_source
    logic [7:0]  chars[$];
    int unsigned drain;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every spelling plus unknown bytes; region and strand change mid-window,
    // and the final character still releases a k-mer
    chars = '{CHAR_UC_A, kecf_pkg::CHAR_UC_C, kecf_pkg::CHAR_UC_G, kecf_pkg::CHAR_UC_T,
              CHAR_LC_A, kecf_pkg::CHAR_LC_C, kecf_pkg::CHAR_LC_G, kecf_pkg::CHAR_LC_T,
              8'h00, CHAR_UC_N, 8'hFF, kecf_pkg::CHAR_LC_G, kecf_pkg::CHAR_UC_C,
              kecf_pkg::CHAR_UC_T};
    send_listed(chars, '0, 1'b0, 6);

    // Sequence too short to fill the window
    chars = '{kecf_pkg::CHAR_LC_G};
    send_listed(chars, 20'h5A5A5, 1'b1, 1);

    // Complexity limit: eleven of one base dropped, then ten kept
    chars = {};
    repeat (11) chars = {chars, CHAR_UC_A};
    repeat (3) chars = {chars, kecf_pkg::CHAR_UC_C};
    send_listed(chars, 20'hA5A5A, 1'b0, chars.size());

    while (items_sent < ITEM_TARGET) send_random_sequence();
    base_valid <= 1'b0;

    // Drain, then allow the output latency to run out
    drain = 0;
    while (tracker.pending() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d expected kmer words never arrived", tracker.pending());
      tracker.errors++;
    end

    if (tracker.errors == 0) begin
      $display("** kmer_extract_complexity_filter_core: PASSED **");
    end else begin
      $display("** kmer_extract_complexity_filter_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/kecf_pkg.sv
src/kecf_cell.sv
src/kecf_tally.sv
src/kmer_extract_complexity_filter_core.sv
tb/sv/kmer_extract_complexity_filter_core_tb.sv
